// ===== sv/sliding_window_cross_correlator_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window cross correlator
// Concurrent checks on the clk / rst_n domain, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_CROSS_CORRELATOR_TOP_ASSERT_SVH
`define SLIDING_WINDOW_CROSS_CORRELATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// check a property on every rising clk edge outside reset
`define SWCC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("swcc check failed");

// same, with a message of the caller's choosing
`define SWCC_ASSERT_MSG(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`else

`define SWCC_ASSERT(label, prop)
`define SWCC_ASSERT_MSG(label, prop, msg)

`endif

`endif

// ===== sv/swcc_pkg.sv =====
// ----------------------------------------------------------------------------
// swcc_pkg
// Sizes, codes and types shared by the cross correlator modules.
// ----------------------------------------------------------------------------
package swcc_pkg;

    localparam int WINDOW         = 16;
    localparam int SAMPLE_BITS    = 16;
    localparam int FIELD_BITS     = 16;   // width of a sample on the port
    localparam int LAGS           = 2 * WINDOW - 1;
    localparam int SLOT_BITS      = $clog2(LAGS);
    localparam int SUM_BITS       = 36;
    localparam int IN_TDATA_BITS  = ((2 * FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((SUM_BITS + 7) / 8) * 8;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_READ
    } swcc_state_t;

endpackage

// ===== sv/swcc_tap.sv =====
// ----------------------------------------------------------------------------
// swcc_tap
// One stage of the sample delay line: holds an a/b pair, passes it on a push.
// ----------------------------------------------------------------------------
module swcc_tap
    import swcc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    shift,
    input  sample_t a_in,
    input  sample_t b_in,
    output sample_t a_out,
    output sample_t b_out
);

    sample_t a_reg;
    sample_t b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
        end
        else if (shift)
        begin
            a_reg <= a_in;
            b_reg <= b_in;
        end
    end

    assign a_out = a_reg;
    assign b_out = b_reg;

endmodule

// ===== sv/swcc_lag_cell.sv =====
// ----------------------------------------------------------------------------
// swcc_lag_cell
// Running windowed sum for one lag: adds the entering product, drops the
// product that leaves the window.
// ----------------------------------------------------------------------------
module swcc_lag_cell
    import swcc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    acc_en,
    input  sample_t enter_a,
    input  sample_t enter_b,
    input  sample_t leave_a,
    input  sample_t leave_b,
    output sum_t    sum
);

    logic signed [2*SAMPLE_BITS-1:0] enter_p_reg;
    logic signed [2*SAMPLE_BITS-1:0] leave_p_reg;
    sum_t sum_reg;
    sum_t sum_next;

    // products registered every cycle; only used in the accumulate step
    always_ff @(posedge clk)
    begin
        enter_p_reg <= (2*SAMPLE_BITS)'(enter_a) * (2*SAMPLE_BITS)'(enter_b);
        leave_p_reg <= (2*SAMPLE_BITS)'(leave_a) * (2*SAMPLE_BITS)'(leave_b);
    end

    assign sum_next = sum_reg + SUM_BITS'(enter_p_reg) - SUM_BITS'(leave_p_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (acc_en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

// ===== sv/sliding_window_cross_correlator_top.sv =====
// ----------------------------------------------------------------------------
// sliding_window_cross_correlator_top
// Windowed cross-correlation of two sample streams over all lags.
// ----------------------------------------------------------------------------
// A push item (tuser = 0) takes a sample pair and updates the sums of all
// 2*WINDOW-1 lags at once through delay line shift, product register and
// accumulate, and gives no result. A read item (tuser = 1) is accepted and
// then gives one result per lag, lag -(WINDOW-1) first, at one result per
// cycle while tready is high, through the single output port, the final lag
// marked by tlast; 31 results for WINDOW = 16. The input is not ready while
// a push is in flight or a read is being delivered. Every lag has its own
// cell with two multipliers, so the push time does not depend on WINDOW.
// Reset clears all but the product registers, with no clearing pass after
// it; sums taken before WINDOW pushes count the missing samples as zero.
// ----------------------------------------------------------------------------
module sliding_window_cross_correlator_top
    import swcc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // slave side
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,   // [15:0] sample_a, [31:16] sample_b
    input  logic                      s_axis_tuser,   // [0] action
    // master side
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,   // [35:0] corr_value, rest zero
    output logic [SLOT_BITS-1:0]      m_axis_tuser,   // [4:0] lag_slot
    output logic                      m_axis_tlast    // last lag of a read
);

    `include "sliding_window_cross_correlator_top_assert.svh"

    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(LAGS - 1);

    swcc_state_t          state_reg;
    swcc_state_t          state_next;
    logic [SLOT_BITS-1:0] slot_reg;
    logic [SLOT_BITS-1:0] slot_next;

    logic in_acc;
    logic out_acc;
    logic push_en;
    logic acc_en;

    // hist_x[i] is the sample pushed i pushes ago (0 = newest)
    sample_t hist_a [0:WINDOW];
    sample_t hist_b [0:WINDOW];
    sum_t    sums   [0:LAGS-1];

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign push_en = in_acc && (s_axis_tuser == ACT_PUSH);
    assign acc_en  = (state_reg == ST_ACC);

    // ---- sample delay line: WINDOW+1 taps, handed on at each push
    genvar gi;
    generate
        for (gi = 0; gi <= WINDOW; gi++)
        begin : g_tap
            if (gi == 0)
            begin : g_head
                swcc_tap u_tap
                (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (push_en),
                    .a_in  (sample_t'(SAMPLE_BITS'(s_axis_tdata[FIELD_BITS-1:0]))),
                    .b_in  (sample_t'(SAMPLE_BITS'(s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS]))),
                    .a_out (hist_a[gi]),
                    .b_out (hist_b[gi])
                );
            end
            else
            begin : g_body
                swcc_tap u_tap
                (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (push_en),
                    .a_in  (hist_a[gi-1]),
                    .b_in  (hist_b[gi-1]),
                    .a_out (hist_a[gi]),
                    .b_out (hist_b[gi])
                );
            end
        end
    endgenerate

    // ---- one cell per lag
    // negative lag -d: enters a[d]*b[0], leaves a[W]*b[W-d]
    // lag +k (k >= 0):  enters a[0]*b[k], leaves a[W-k]*b[W]
    // The leaving product is the one that entered W-|lag| pushes ago.
    genvar gs;
    generate
        for (gs = 0; gs < LAGS; gs++)
        begin : g_lag
            if (gs < WINDOW - 1)
            begin : g_neg
                localparam int D = WINDOW - 1 - gs;
                swcc_lag_cell u_cell
                (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .acc_en  (acc_en),
                    .enter_a (hist_a[D]),
                    .enter_b (hist_b[0]),
                    .leave_a (hist_a[WINDOW]),
                    .leave_b (hist_b[WINDOW-D]),
                    .sum     (sums[gs])
                );
            end
            else
            begin : g_pos
                localparam int K = gs - (WINDOW - 1);
                swcc_lag_cell u_cell
                (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .acc_en  (acc_en),
                    .enter_a (hist_a[0]),
                    .enter_b (hist_b[K]),
                    .leave_a (hist_a[WINDOW-K]),
                    .leave_b (hist_b[WINDOW]),
                    .sum     (sums[gs])
                );
            end
        end
    endgenerate

    // ---- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                slot_next = '0;
                if (in_acc)
                begin
                    state_next = (s_axis_tuser == ACT_READ) ? ST_READ : ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                if (out_acc)
                begin
                    if (slot_reg == LAST_SLOT)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        slot_next = slot_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---- ports; sums stay put during a read, so the item holds on a stall
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_READ);
    assign m_axis_tdata  = {{(OUT_TDATA_BITS-SUM_BITS){1'b0}}, sums[slot_reg]};
    assign m_axis_tuser  = slot_reg;
    assign m_axis_tlast  = (slot_reg == LAST_SLOT);

    // ---- checks
    `SWCC_ASSERT_MSG(a_one_side, !(s_axis_tready && m_axis_tvalid), "in and out both open")
    `SWCC_ASSERT_MSG(a_push_busy, push_en |=> !s_axis_tready ##1 !s_axis_tready, "push too short")
    `SWCC_ASSERT_MSG(a_read_start, (in_acc && (s_axis_tuser == ACT_READ)) |=> (m_axis_tvalid && (m_axis_tuser == '0)), "read does not start at first lag")
    `SWCC_ASSERT(a_slot_step, (out_acc && !m_axis_tlast) |=> (m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 1'b1)))

endmodule
